/* rtl/yfmb_pkg.sv */
`default_nettype none
package yfmb_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and state widths
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int TOTAL_W = 28;
  localparam int COUNT_W = 20;
  localparam int AREA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int Q_SHIFT = 16;

  // Signed Q16 channel value: luma plus chroma terms
  localparam int CH_W = 27;

  // Mean divider: one guard bit above the quotient flags saturation
  localparam int DIV_STEPS = PIX_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIV_W     = (AREA_W + PIX_W > TOTAL_W) ? AREA_W + PIX_W : TOTAL_W;

  // Brightness weighting
  localparam int WGT_W  = 16;
  localparam int WSUM_W = PIX_W + Q_SHIFT;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd160;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd120;

  // Color conversion coefficients, Q16
  localparam logic signed [CH_W-1:0] Q_R_V = CH_W'(91881);
  localparam logic signed [CH_W-1:0] Q_G_U = CH_W'(22544);
  localparam logic signed [CH_W-1:0] Q_G_V = CH_W'(46793);
  localparam logic signed [CH_W-1:0] Q_B_U = CH_W'(116130);
  localparam logic signed [8:0]      CHROMA_OFFSET = 9'sd128;

  // Luma weights, Q16; they sum to one
  localparam logic [WGT_W-1:0] W_R = 16'd19595;
  localparam logic [WGT_W-1:0] W_G = 16'd38470;
  localparam logic [WGT_W-1:0] W_B = 16'd7471;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } yfmb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] brightness;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
  } yfmb_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } yfmb_rgb_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_FLUSH,
    ST_LOAD,
    ST_DIVIDE,
    ST_WEIGH,
    ST_EMIT
  } state_t;

  // Floor a Q16 value and clip it to the pixel range
  function automatic logic [PIX_W-1:0] clip_q16(input logic signed [CH_W-1:0] v);
    logic [CH_W-Q_SHIFT-1:0] whole;
    whole = v[CH_W-1:Q_SHIFT];
    if (v <= 0) begin
      return '0;
    end else if (whole > (CH_W-Q_SHIFT)'({PIX_W{1'b1}})) begin
      return '1;
    end else begin
      return whole[PIX_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/yfmb_lane.sv */
`default_nettype none
module yfmb_lane import yfmb_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [PIX_W-1:0] luma,
  input  logic [PIX_W-1:0] chroma_blue,
  input  logic [PIX_W-1:0] chroma_red,
  output yfmb_rgb_t        rgb
);

  logic signed [8:0]      cb_s;
  logic signed [8:0]      cr_s;
  logic signed [CH_W-1:0] base;
  logic signed [CH_W-1:0] r_q;
  logic signed [CH_W-1:0] g_q;
  logic signed [CH_W-1:0] b_q;

  assign cb_s = signed'({1'b0, chroma_blue}) - CHROMA_OFFSET;
  assign cr_s = signed'({1'b0, chroma_red}) - CHROMA_OFFSET;
  assign base = signed'(CH_W'({luma, {Q_SHIFT{1'b0}}}));

  assign r_q = base + Q_R_V * CH_W'(cr_s);
  assign g_q = base - Q_G_U * CH_W'(cb_s) - Q_G_V * CH_W'(cr_s);
  assign b_q = base + Q_B_U * CH_W'(cb_s);

  always_ff @(posedge clk) begin
    if (en) begin
      rgb <= '{r: clip_q16(r_q), g: clip_q16(g_q), b: clip_q16(b_q)};
    end
  end

endmodule
`default_nettype wire

/* rtl/yfmb_div.sv */
`default_nettype none
module yfmb_div import yfmb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] total,
  input  logic [AREA_W-1:0]  area,
  output logic               busy,
  output logic [PIX_W-1:0]   mean
);

  // Restoring division, one quotient bit per cycle, top bit flags overflow
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsh;
  logic [DIV_STEPS-1:0] quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 take;

  assign take = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DIV_W'(total);
      dsh  <= DIV_W'(area) << PIX_W;
      quot <= '0;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (take) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[DIV_STEPS-2:0], take};
      cnt  <= cnt - 1'b1;
    end
  end

  assign mean = quot[DIV_STEPS-1] ? '1 : quot[PIX_W-1:0];

endmodule
`default_nettype wire

/* rtl/yuyv_frame_mean_brightness.sv */
`default_nettype none
// Frame mean brightness of a YUYV 4:2:2 stream. Each input item is one pixel
// pair (two lumas sharing one Cb and one Cr). Two conversion lanes turn the
// two pixels into clipped 8-bit R, G and B with Q16 coefficients, and a merge
// stage adds both lanes into 28-bit red, green and blue sums. When the pair
// count reaches width*height/2 the block divides each sum by the pixel count
// (floored, saturated at 255), weights the means into a brightness value and
// presents one result item; the sums then restart at zero. Within a frame an
// item is taken every cycle. After the item that closes a frame, the input
// is stalled while the block drains the lanes, loads the three mean
// dividers, runs the bit-serial divide (nine quotient bits, the top one
// flagging saturation), registers the weight products and loads the
// output register, plus any time the previous result still sits unread.
// The output register lets the next frame stream in while a result waits.
// frame_width (index 0) is clamped to 2..MAX_WIDTH and forced even;
// frame_height (index 1) is clamped to 1..MAX_HEIGHT. Write them only while
// the block is idle; the configuration port is always ready.
module yuyv_frame_mean_brightness import yfmb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  yfmb_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output yfmb_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // Effective geometry
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [2*DIM_W-1:0] area_full;
  logic [AREA_W-1:0]  area;
  logic [COUNT_W-1:0] pair_target;

  // Control
  state_t             state;
  state_t             state_next;
  logic               in_acc;
  logic [COUNT_W-1:0] pair_count;
  logic [COUNT_W-1:0] count_inc;
  logic               frame_end;
  logic               lane_valid;
  logic               div_start;
  logic [2:0]         div_busy;
  logic               out_load;

  // Datapath
  yfmb_rgb_t          lane_rgb [2];
  logic [TOTAL_W-1:0] red_total;
  logic [TOTAL_W-1:0] green_total;
  logic [TOTAL_W-1:0] blue_total;
  logic [PIX_W-1:0]   mean_red;
  logic [PIX_W-1:0]   mean_green;
  logic [PIX_W-1:0]   mean_blue;
  logic [WSUM_W-1:0]  prod_r;
  logic [WSUM_W-1:0]  prod_g;
  logic [WSUM_W-1:0]  prod_b;
  logic [WSUM_W-1:0]  wsum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry; width is forced even after clamping
  always_comb begin
    w_eff = frame_width;
    if (w_eff < DIM_W'(2)) begin
      w_eff = DIM_W'(2);
    end
    if (w_eff > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    w_eff[0] = 1'b0;
    h_eff = frame_height;
    if (h_eff < DIM_W'(1)) begin
      h_eff = DIM_W'(1);
    end
    if (h_eff > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  assign area_full   = w_eff * h_eff;
  assign area        = AREA_W'(area_full);
  assign pair_target = COUNT_W'(area >> 1);

  // Input side: take a pair only while streaming a frame
  assign in_stall  = (state != ST_RUN);
  assign in_acc    = in_valid && !in_stall;
  assign count_inc = pair_count + 1'b1;
  assign frame_end = (count_inc >= pair_target);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      lane_valid <= 1'b0;
    end else begin
      lane_valid <= in_acc;
      if (in_acc) begin
        pair_count <= frame_end ? '0 : count_inc;
      end
    end
  end

  // One lane per pixel of the pair
  yfmb_lane u_lane_first (
    .clk         (clk),
    .en          (in_acc),
    .luma        (in_data.luma_first),
    .chroma_blue (in_data.chroma_blue),
    .chroma_red  (in_data.chroma_red),
    .rgb         (lane_rgb[0])
  );

  yfmb_lane u_lane_second (
    .clk         (clk),
    .en          (in_acc),
    .luma        (in_data.luma_second),
    .chroma_blue (in_data.chroma_blue),
    .chroma_red  (in_data.chroma_red),
    .rgb         (lane_rgb[1])
  );

  // Merge both lanes into the running sums; clear them once handed to the dividers
  always_ff @(posedge clk) begin
    if (rst || state == ST_LOAD) begin
      red_total   <= '0;
      green_total <= '0;
      blue_total  <= '0;
    end else if (lane_valid) begin
      red_total   <= red_total + TOTAL_W'(lane_rgb[0].r) + TOTAL_W'(lane_rgb[1].r);
      green_total <= green_total + TOTAL_W'(lane_rgb[0].g) + TOTAL_W'(lane_rgb[1].g);
      blue_total  <= blue_total + TOTAL_W'(lane_rgb[0].b) + TOTAL_W'(lane_rgb[1].b);
    end
  end

  // One divider per channel, all started together
  yfmb_div u_div_red (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .total (red_total),
    .area  (area),
    .busy  (div_busy[0]),
    .mean  (mean_red)
  );

  yfmb_div u_div_green (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .total (green_total),
    .area  (area),
    .busy  (div_busy[1]),
    .mean  (mean_green)
  );

  yfmb_div u_div_blue (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .total (blue_total),
    .area  (area),
    .busy  (div_busy[2]),
    .mean  (mean_blue)
  );

  // Brightness weighting: products registered, summed ahead of the output register
  always_ff @(posedge clk) begin
    prod_r <= WSUM_W'(W_R) * WSUM_W'(mean_red);
    prod_g <= WSUM_W'(W_G) * WSUM_W'(mean_green);
    prod_b <= WSUM_W'(W_B) * WSUM_W'(mean_blue);
  end

  assign wsum = prod_r + prod_g + prod_b;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_RUN: begin
        if (in_acc && frame_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_busy == '0) begin
          state_next = ST_WEIGH;
        end
      end
      ST_WEIGH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Output register: hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{brightness: wsum[WSUM_W-1:Q_SHIFT],
                    mean_red:   mean_red,
                    mean_green: mean_green,
                    mean_blue:  mean_blue};
    end
  end

  // The item that closes a frame blocks the next one
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && frame_end) |=> in_stall)
    else $error("input taken right after the frame-closing item");

  // Sums must be cleared once the dividers own them
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |->
      (red_total == '0 && green_total == '0 && blue_total == '0))
    else $error("running sums not cleared during divide");

  // Lane output only ever lands while streaming or draining
  assert property (@(posedge clk) disable iff (rst)
    lane_valid |-> (state == ST_RUN || state == ST_FLUSH))
    else $error("lane output arrived outside a frame");

  // Dividers are idle whenever pairs are taken
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (div_busy == '0))
    else $error("divider busy while streaming");

  // A pending unread result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_valid && out_stall) |=> (state == ST_EMIT))
    else $error("result loaded over an unread one");

endmodule
`default_nettype wire

/* bench/tb_yuyv_frame_mean_brightness.sv */
`timescale 1ns / 1ps
module tb_yuyv_frame_mean_brightness;
  import yfmb_pkg::*;

  // Conversion coefficients, signed Q16, and luma weights that sum to one
  localparam int CR_TO_RED   = 91881;
  localparam int CB_TO_GREEN = 22544;
  localparam int CR_TO_GREEN = 46793;
  localparam int CB_TO_BLUE  = 116130;
  localparam int unsigned WEIGHT_RED   = 19595;
  localparam int unsigned WEIGHT_GREEN = 38470;
  localparam int unsigned WEIGHT_BLUE  = 7471;
  localparam int LINE_LIMIT  = 1024;
  localparam int LINES_LIMIT = 1024;

  // Pipeline drain plus the end-of-frame divide, with margin
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_ITEMS   = 1200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  yfmb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  yfmb_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  yuyv_frame_mean_brightness u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: geometry registers, channel sums, pair count
  logic [DIM_W-1:0] width_reg  = FRAME_WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = FRAME_HEIGHT_RESET;
  logic [27:0]      red_sum    = '0;
  logic [27:0]      green_sum  = '0;
  logic [27:0]      blue_sum   = '0;
  logic [19:0]      frame_pairs = '0;

  yfmb_in_t  pair_backlog[$];   // items waiting to be driven
  yfmb_out_t pending_means[$];  // frame results still owed by the block

  bit pair_taken = 1'b0;
  bit idle_on    = 1'b0;
  int src_gap    = 0;
  int sink_gap   = 0;
  int mismatches = 0;
  int pairs_fed  = 0;
  int frames_closed = 0;
  int geometries = 0;

  // Clamp the geometry as the block does and return the pixel count
  function automatic int unsigned frame_area(input logic [DIM_W-1:0] w,
                                             input logic [DIM_W-1:0] h);
    int unsigned ew;
    int unsigned eh;
    ew = w;
    eh = h;
    if (ew < 2) ew = 2;
    if (ew > LINE_LIMIT) ew = LINE_LIMIT;
    ew = ew & ~32'd1;
    if (eh < 1) eh = 1;
    if (eh > LINES_LIMIT) eh = LINES_LIMIT;
    return ew * eh;
  endfunction

  // Floor a Q16 channel value, clip to 0..255
  function automatic logic [7:0] clip_channel(input int v);
    int u;
    if (v <= 0) return 8'd0;
    u = v >>> 16;
    return (u > 255) ? 8'd255 : u[7:0];
  endfunction

  function automatic logic [7:0] sat_mean(input logic [27:0] total,
                                          input int unsigned area);
    int unsigned q;
    q = total / area;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Fold one accepted pair into the sums; close the frame once the pair
  // count reaches or passes the current target
  task automatic fold_pair(input yfmb_in_t p);
    int cb;
    int cr;
    int base;
    int unsigned area;
    int unsigned wsum;
    logic [7:0] lumas [2];
    yfmb_out_t means;
    cb = int'(p.chroma_blue) - 128;
    cr = int'(p.chroma_red) - 128;
    lumas[0] = p.luma_first;
    lumas[1] = p.luma_second;
    for (int k = 0; k < 2; k++) begin
      base = int'(lumas[k]) * 65536;
      red_sum   = red_sum   + 28'(clip_channel(base + CR_TO_RED * cr));
      green_sum = green_sum + 28'(clip_channel(base - CB_TO_GREEN * cb - CR_TO_GREEN * cr));
      blue_sum  = blue_sum  + 28'(clip_channel(base + CB_TO_BLUE * cb));
    end
    frame_pairs = frame_pairs + 20'd1;
    area = frame_area(width_reg, height_reg);
    if (frame_pairs >= area / 2) begin
      means.mean_red   = sat_mean(red_sum, area);
      means.mean_green = sat_mean(green_sum, area);
      means.mean_blue  = sat_mean(blue_sum, area);
      wsum = WEIGHT_RED * means.mean_red + WEIGHT_GREEN * means.mean_green
           + WEIGHT_BLUE * means.mean_blue;
      wsum = wsum >> 16;
      means.brightness = (wsum > 255) ? 8'd255 : wsum[7:0];
      pending_means.push_back(means);
      frames_closed++;
      red_sum = '0;
      green_sum = '0;
      blue_sum = '0;
      frame_pairs = '0;
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: sample every handshake at the rising edge
  always @(posedge clk) begin
    pair_taken = in_valid && !in_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg  = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (pair_taken) begin
        fold_pair(in_data);
        pairs_fed++;
      end
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $error("frame result with no frame closed: %h", out_data);
          mismatches++;
        end else begin
          check_field("brightness", pending_means[0].brightness, out_data.brightness);
          check_field("mean_red",   pending_means[0].mean_red,   out_data.mean_red);
          check_field("mean_green", pending_means[0].mean_green, out_data.mean_green);
          check_field("mean_blue",  pending_means[0].mean_blue,  out_data.mean_blue);
          void'(pending_means.pop_front());
        end
      end
    end
  end

  // Driver: hold a stalled item, otherwise idle in bursts or advance
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !pair_taken) begin
      // hold the payload until it is taken
    end else if (src_gap != 0) begin
      src_gap--;
      in_valid <= 1'b0;
    end else if (pair_backlog.size() != 0) begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pair_backlog.pop_front();
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall in random bursts while idling is on
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_pair(input int y0, input int cb, input int y1, input int cr);
    yfmb_in_t p;
    p.luma_first  = y0[7:0];
    p.chroma_blue = cb[7:0];
    p.luma_second = y1[7:0];
    p.chroma_red  = cr[7:0];
    pair_backlog.push_back(p);
  endtask

  // Lean toward the range ends and the neutral chroma point
  function automatic int pick_sample();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2: return 128;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Wait until every item is taken and every frame result is back, then
  // let the lanes drain before touching the geometry
  task automatic settle();
    while (pair_backlog.size() != 0 || in_valid || pending_means.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_items;
    int phase_no;
    int unsigned target;
    int n;
    rand_items = 0;
    phase_no = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Partial frame at reset geometry, then shrink it mid frame: the sums
    // carry over and the means saturate
    queue_pair(255, 255, 255, 255);
    queue_pair(255, 0, 255, 0);
    queue_pair(200, 128, 255, 128);
    queue_pair(255, 128, 255, 128);
    queue_pair(240, 60, 250, 200);
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd2);
    write_reg(CFG_FRAME_HEIGHT, 11'd1);
    queue_pair(255, 128, 255, 128);

    // One pair per frame: extremes of luma and chroma, clipping both ways
    settle();
    queue_pair(0, 0, 0, 0);
    queue_pair(255, 255, 255, 255);
    queue_pair(255, 0, 255, 0);
    queue_pair(0, 255, 0, 255);
    queue_pair(255, 128, 0, 128);
    queue_pair(128, 0, 128, 255);
    queue_pair(0, 128, 255, 0);
    queue_pair(16, 128, 235, 128);

    // Geometry below range, odd widths
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    write_reg(CFG_FRAME_HEIGHT, 11'd0);
    queue_pair(100, 90, 30, 200);
    queue_pair(7, 250, 180, 3);
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd1);
    queue_pair(60, 128, 61, 128);
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd1);
    queue_pair(250, 10, 5, 240);
    settle();
    write_reg(CFG_FRAME_WIDTH, 11'd5);
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    repeat (4) queue_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());

    // Random frames over many geometries; partial frames carry into the
    // next geometry. Drop idling for the tail of the run.
    while (rand_items < RAND_ITEMS) begin
      settle();
      idle_on = (rand_items < RAND_ITEMS - 200) && ($urandom_range(0, 3) != 0);
      if (phase_no == 2) begin
        // width above range: clamps to the widest line
        write_reg(CFG_FRAME_WIDTH, 11'd2047);
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
      end else if (phase_no == 5) begin
        // height above range: no frame may close early
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd2047);
      end else begin
        // always shrink back right after an oversized geometry
        if (phase_no == 3 || phase_no == 6 || $urandom_range(0, 4) != 0)
          write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(0, 12)));
        if (phase_no == 3 || phase_no == 6 || $urandom_range(0, 4) != 0)
          write_reg(CFG_FRAME_HEIGHT, DIM_W'($urandom_range(0, 5)));
      end
      target = frame_area(width_reg, height_reg) / 2;
      if (phase_no == 5) begin
        n = 40;
      end else if (target > 60) begin
        n = target;
      end else begin
        n = $urandom_range(1, 3) * target;
        if ($urandom_range(0, 3) == 0)
          n += $urandom_range(1, target);
      end
      repeat (n) queue_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      rand_items += n;
      phase_no++;
      geometries++;
    end

    settle();
    $display("Fed %0d pixel pairs, checked %0d frame results over %0d random geometries",
             pairs_fed, frames_closed, geometries);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
